@@ sv/bdl_pkg.sv @@
package bdl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 7;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int STAT_W      = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PREPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_AT_HEAD   = 2'd3;

  typedef struct packed {
    logic              val_we;
    logic              next_we;
    logic              prev_we;
    logic [IDX_W-1:0]  val_addr;
    logic [IDX_W-1:0]  next_addr;
    logic [IDX_W-1:0]  prev_addr;
    logic [DATA_W-1:0] val_data;
    logic [IDX_W-1:0]  next_data;
    logic [IDX_W-1:0]  prev_data;
  } store_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [IDX_W-1:0]  next;
    logic [IDX_W-1:0]  prev;
  } store_rd_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] set_idx;
    logic [IDX_W-1:0] clr_idx;
  } map_upd_t;

endpackage

@@ sv/bdl_if.sv @@
interface bdl_in_if;
  logic                              valid;
  logic                              ready;
  logic [bdl_pkg::MODE_W-1:0]        mode;
  logic signed [bdl_pkg::DATA_W-1:0] value;
  logic signed [bdl_pkg::DATA_W-1:0] new_value;
  modport source (output valid, mode, value, new_value, input ready);
  modport sink (input valid, mode, value, new_value, output ready);
endinterface

interface bdl_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdl_pkg::STAT_W-1:0] status;
  logic [bdl_pkg::CNT_W-1:0]  position;
  logic [bdl_pkg::CNT_W-1:0]  count;
  modport source (output valid, status, position, count, input ready);
  modport sink (input valid, status, position, count, output ready);
endinterface

@@ sv/bdl_store.sv @@
module bdl_store (
  input  logic                          clk,
  input  logic [bdl_pkg::IDX_W-1:0]     rd_addr,
  input  bdl_pkg::store_wr_t            wr,
  output bdl_pkg::store_rd_t            rd
);

  logic [bdl_pkg::DATA_W-1:0] val_mem  [bdl_pkg::MAX_ENTRIES];
  logic [bdl_pkg::IDX_W-1:0]  next_mem [bdl_pkg::MAX_ENTRIES];
  logic [bdl_pkg::IDX_W-1:0]  prev_mem [bdl_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr.val_addr] <= wr.val_data;
    end
    rd.val <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    rd.next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
    rd.prev <= prev_mem[rd_addr];
  end

endmodule

@@ sv/bdl_free.sv @@
module bdl_free (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdl_pkg::map_upd_t                 upd,
  output logic [bdl_pkg::MAX_ENTRIES-1:0]   in_use,
  output logic [bdl_pkg::IDX_W-1:0]         free_slot
);

  logic [bdl_pkg::MAX_ENTRIES-1:0] in_use_r;
  logic [bdl_pkg::IDX_W-1:0]       free_r;
  logic [bdl_pkg::IDX_W-1:0]       free_nxt;

  always_comb begin
    free_nxt = '0;
    for (int k = bdl_pkg::MAX_ENTRIES - 1; k >= 0; k--) begin
      if (!in_use_r[k]) begin
        free_nxt = bdl_pkg::IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      free_r   <= '0;
    end else begin
      free_r <= free_nxt;
      if (upd.set) begin
        in_use_r[upd.set_idx] <= 1'b1;
      end
      if (upd.clr) begin
        in_use_r[upd.clr_idx] <= 1'b0;
      end
    end
  end

  assign in_use    = in_use_r;
  assign free_slot = free_r;

endmodule

@@ sv/bdl_ctrl.sv @@
module bdl_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  bdl_in_if.sink                        in_ch,
  bdl_out_if.source                     out_ch,
  input  bdl_pkg::store_rd_t            rd,
  output logic [bdl_pkg::IDX_W-1:0]     rd_addr,
  output bdl_pkg::store_wr_t            wr,
  output bdl_pkg::map_upd_t             upd,
  input  logic [bdl_pkg::IDX_W-1:0]     free_slot,
  output logic [bdl_pkg::CNT_W-1:0]     count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DEL_WR = 3'd3;
  localparam logic [2:0] S_INS1   = 3'd4;
  localparam logic [2:0] S_INS2   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [bdl_pkg::CNT_W-1:0] FULL_CNT = bdl_pkg::CNT_W'(bdl_pkg::MAX_ENTRIES);

  logic [2:0]                   state_r, state_nxt;
  logic [bdl_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [bdl_pkg::DATA_W-1:0]   key_r, key_nxt;
  logic [bdl_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic [bdl_pkg::IDX_W-1:0]    head_r, head_nxt;
  logic [bdl_pkg::IDX_W-1:0]    tail_r, tail_nxt;
  logic [bdl_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [bdl_pkg::IDX_W-1:0]    cur_r, cur_nxt;
  logic [bdl_pkg::CNT_W-1:0]    step_r, step_nxt;
  logic [bdl_pkg::IDX_W-1:0]    match_r, match_nxt;
  logic [bdl_pkg::IDX_W-1:0]    prevm_r, prevm_nxt;
  logic [bdl_pkg::IDX_W-1:0]    victim_r, victim_nxt;
  logic [bdl_pkg::IDX_W-1:0]    new_r, new_nxt;
  logic [bdl_pkg::STAT_W-1:0]   stat_r, stat_nxt;
  logic [bdl_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bdl_pkg::STAT_W-1:0]   out_stat_r, out_stat_nxt;
  logic [bdl_pkg::CNT_W-1:0]    out_pos_r, out_pos_nxt;
  logic [bdl_pkg::CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                         accept;
  logic                         hit;
  logic                         full;

  assign accept = in_ch.valid && in_ch.ready;
  assign hit    = (rd.val == key_r);
  assign full   = (count_r >= FULL_CNT);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    match_nxt     = match_r;
    prevm_nxt     = prevm_r;
    victim_nxt    = victim_r;
    new_nxt       = new_r;
    stat_nxt      = stat_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_stat_nxt  = out_stat_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    rd_addr       = cur_r;
    wr            = '0;
    upd           = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = head_r;
        if (accept) begin
          mode_nxt = in_ch.mode;
          key_nxt  = in_ch.value;
          data_nxt = in_ch.new_value;
          cur_nxt  = head_r;
          step_nxt = '0;
          stat_nxt = bdl_pkg::STAT_DONE;
          pos_nxt  = '0;
          state_nxt = S_DONE;
          priority case (in_ch.mode)
            bdl_pkg::MODE_APPEND, bdl_pkg::MODE_PREPEND: begin
              if (full) begin
                stat_nxt = bdl_pkg::STAT_FULL;
              end else begin
                state_nxt = S_APPEND;
              end
            end
            bdl_pkg::MODE_FIND, bdl_pkg::MODE_DELETE: begin
              if (count_r == '0) begin
                stat_nxt = bdl_pkg::STAT_NOT_FOUND;
              end else begin
                state_nxt = S_WALK;
              end
            end
            bdl_pkg::MODE_INSERT: begin
              if (full) begin
                stat_nxt = bdl_pkg::STAT_FULL;
              end else if (count_r == '0) begin
                stat_nxt = bdl_pkg::STAT_NOT_FOUND;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              stat_nxt = bdl_pkg::STAT_DONE;
            end
          endcase
        end
      end
      S_APPEND: begin
        wr.val_we    = 1'b1;
        wr.val_addr  = free_slot;
        wr.val_data  = key_r;
        upd.set      = 1'b1;
        upd.set_idx  = free_slot;
        count_nxt    = count_r + 1'b1;
        state_nxt    = S_DONE;
        if (count_r == '0) begin
          head_nxt = free_slot;
          tail_nxt = free_slot;
        end else if (mode_r == bdl_pkg::MODE_APPEND) begin
          wr.next_we   = 1'b1;
          wr.next_addr = tail_r;
          wr.next_data = free_slot;
          wr.prev_we   = 1'b1;
          wr.prev_addr = free_slot;
          wr.prev_data = tail_r;
          tail_nxt     = free_slot;
        end else begin
          wr.prev_we   = 1'b1;
          wr.prev_addr = head_r;
          wr.prev_data = free_slot;
          wr.next_we   = 1'b1;
          wr.next_addr = free_slot;
          wr.next_data = head_r;
          head_nxt     = free_slot;
        end
      end
      S_WALK: begin
        rd_addr = hit ? rd.prev : rd.next;
        if (!hit) begin
          if (step_r + 1'b1 == count_r) begin
            stat_nxt  = bdl_pkg::STAT_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            cur_nxt  = rd.next;
            step_nxt = step_r + 1'b1;
          end
        end else begin
          match_nxt = cur_r;
          prevm_nxt = rd.prev;
          state_nxt = S_DONE;
          priority case (mode_r)
            bdl_pkg::MODE_FIND: begin
              pos_nxt = step_r + 1'b1;
            end
            bdl_pkg::MODE_DELETE: begin
              if (step_r == '0) begin
                stat_nxt = bdl_pkg::STAT_AT_HEAD;
              end else if (rd.prev == head_r) begin
                head_nxt    = cur_r;
                upd.clr     = 1'b1;
                upd.clr_idx = rd.prev;
                count_nxt   = count_r - 1'b1;
              end else begin
                victim_nxt = rd.prev;
                state_nxt  = S_DEL_WR;
              end
            end
            default: begin
              state_nxt = S_INS1;
            end
          endcase
        end
      end
      S_DEL_WR: begin
        wr.next_we   = 1'b1;
        wr.next_addr = rd.prev;
        wr.next_data = match_r;
        wr.prev_we   = 1'b1;
        wr.prev_addr = match_r;
        wr.prev_data = rd.prev;
        upd.clr      = 1'b1;
        upd.clr_idx  = victim_r;
        count_nxt    = count_r - 1'b1;
        state_nxt    = S_DONE;
      end
      S_INS1: begin
        wr.val_we    = 1'b1;
        wr.val_addr  = free_slot;
        wr.val_data  = data_r;
        wr.next_we   = 1'b1;
        wr.next_addr = free_slot;
        wr.next_data = match_r;
        wr.prev_we   = 1'b1;
        wr.prev_addr = match_r;
        wr.prev_data = free_slot;
        upd.set      = 1'b1;
        upd.set_idx  = free_slot;
        count_nxt    = count_r + 1'b1;
        new_nxt      = free_slot;
        if (match_r == head_r) begin
          head_nxt  = free_slot;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INS2;
        end
      end
      S_INS2: begin
        wr.next_we   = 1'b1;
        wr.next_addr = prevm_r;
        wr.next_data = new_r;
        wr.prev_we   = 1'b1;
        wr.prev_addr = new_r;
        wr.prev_data = prevm_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_pos_nxt   = pos_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    cur_r      <= cur_nxt;
    step_r     <= step_nxt;
    match_r    <= match_nxt;
    prevm_r    <= prevm_nxt;
    victim_r   <= victim_nxt;
    new_r      <= new_nxt;
    stat_r     <= stat_nxt;
    pos_r      <= pos_nxt;
    out_stat_r <= out_stat_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_stat_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.count    = out_cnt_r;
  assign count           = count_r;

endmodule

@@ sv/bounded_doubly_linked_list.sv @@
// Doubly linked list of signed 32-bit values held in a 64-entry store. One beat
// is taken at a time; the input is not ready while a request is in progress.
// A request goes straight to its result without touching the store for a full
// store, an empty list searched, or an unused mode. Find, delete and insert walk
// the links one entry per cycle through the registered read port of the store;
// a miss walks every entry held. Delete removes the entry before the match (a
// match at the head gives STAT_AT_HEAD) and passes through S_DEL_WR as well
// when the entry removed is not the head. Insert-before writes in S_INS1, and
// in S_INS2 as well when the match is not the head. The result sits in an
// output register and the next beat is accepted while it waits.
module bounded_doubly_linked_list (
  input  logic      clk,
  input  logic      rst_n,
  bdl_in_if.sink    in_ch,
  bdl_out_if.source out_ch
);

  bdl_pkg::store_rd_t              rd;
  bdl_pkg::store_wr_t              wr;
  bdl_pkg::map_upd_t               upd;
  logic [bdl_pkg::IDX_W-1:0]       rd_addr;
  logic [bdl_pkg::IDX_W-1:0]       free_slot;
  logic [bdl_pkg::MAX_ENTRIES-1:0] in_use;
  logic [bdl_pkg::CNT_W-1:0]       count;

  bdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .rd        (rd),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .upd       (upd),
    .free_slot (free_slot),
    .count     (count)
  );

  bdl_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  bdl_free u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .in_use    (in_use),
    .free_slot (free_slot)
  );

  a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use) == 32'(count))
    else $error("occupancy map disagrees with entry count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready straight after a beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> 32'(count) <= bdl_pkg::MAX_ENTRIES)
    else $error("entry count beyond store size");

endmodule

@@ sim/bdl_checker.sv @@
module bdl_checker
  import bdl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bdl_in_if.sink       in_mon,
  bdl_out_if.sink      out_mon,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic [DATA_W-1:0] vals [MAX_ENTRIES];
  int                nxt [MAX_ENTRIES];
  int                prv [MAX_ENTRIES];
  bit                used [MAX_ENTRIES];
  int                head, tail, n_held;
  list_result_t      expected_results[$];

  function automatic int lowest_free();
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (!used[i]) return i;
    return 0;
  endfunction

  function automatic bit search_list(logic [DATA_W-1:0] key, int skip,
                                     output int slot, output int pos);
    int cur;
    cur = head;
    slot = 0;
    pos = 0;
    for (int i = 0; i < n_held; i++) begin
      if (i >= skip && vals[cur] == key) begin
        slot = cur;
        pos = i + 1;
        return 1;
      end
      cur = nxt[cur];
    end
    return 0;
  endfunction

  function automatic list_result_t apply_request(logic [MODE_W-1:0] mode,
                                                 logic [DATA_W-1:0] key,
                                                 logic [DATA_W-1:0] data);
    list_result_t r;
    int m, p, n, victim, bf;
    bit full;
    r = '0;
    full = n_held >= MAX_ENTRIES;
    case (mode)
      MODE_APPEND, MODE_PREPEND: begin
        if (full) r.status = STAT_FULL;
        else begin
          n = lowest_free();
          vals[n] = key;
          used[n] = 1;
          if (n_held == 0) begin
            head = n;
            tail = n;
          end else if (mode == MODE_APPEND) begin
            nxt[tail] = n;
            prv[n] = tail;
            tail = n;
          end else begin
            prv[head] = n;
            nxt[n] = head;
            head = n;
          end
          n_held++;
        end
      end
      MODE_FIND: begin
        if (search_list(key, 0, m, p)) r.position = p;
        else r.status = STAT_NOT_FOUND;
      end
      MODE_DELETE: begin
        if (n_held == 0) r.status = STAT_NOT_FOUND;
        else if (vals[head] == key) r.status = STAT_AT_HEAD;
        else if (!search_list(key, 1, m, p)) r.status = STAT_NOT_FOUND;
        else begin
          victim = prv[m];
          if (victim == head) head = m;
          else begin
            bf = prv[victim];
            nxt[bf] = m;
            prv[m] = bf;
          end
          used[victim] = 0;
          n_held--;
        end
      end
      MODE_INSERT: begin
        if (full) r.status = STAT_FULL;
        else if (!search_list(key, 0, m, p)) r.status = STAT_NOT_FOUND;
        else begin
          n = lowest_free();
          vals[n] = data;
          used[n] = 1;
          if (m == head) head = n;
          else begin
            bf = prv[m];
            nxt[bf] = n;
            prv[n] = bf;
          end
          nxt[n] = m;
          prv[m] = n;
          n_held++;
        end
      end
      default: ;
    endcase
    r.count = n_held[CNT_W-1:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    list_result_t got, want;
    if (!rst_n) begin
      head <= 0;
      tail <= 0;
      n_held <= 0;
      fail_count <= 0;
      for (int i = 0; i < MAX_ENTRIES; i++) used[i] <= 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_request(in_mon.mode, in_mon.value,
                                                 in_mon.new_value));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.position, out_mon.count};
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected beat %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                       want.status, want.position, want.count,
                       got.status, got.position, got.count);
          end
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
module testbench;
  import bdl_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   steady;

  bdl_in_if  in_ch ();
  bdl_out_if out_ch ();

  bounded_doubly_linked_list dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  bdl_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                         .fail_count(fail_count), .pending(pending));

  logic [DATA_W-1:0] recent_keys[$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= steady || ($urandom_range(99) >= 32);
  end

  function automatic logic [DATA_W-1:0] pick_key();
    if (recent_keys.size() > 0 && $urandom_range(99) < 75)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom : $urandom_range(15);
  endfunction

  task automatic send_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] key,
                              logic [DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < 32) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= mode;
    in_ch.value <= key;
    in_ch.new_value <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode == MODE_APPEND || mode == MODE_PREPEND || mode == MODE_INSERT) begin
      recent_keys.push_back(mode == MODE_INSERT ? data : key);
      if (recent_keys.size() > 48) void'(recent_keys.pop_front());
    end
  endtask

  initial begin
    int roll;
    logic [MODE_W-1:0] mode;
    rst_n = 0;
    steady = 0;
    in_ch.valid = 0;
    in_ch.mode = MODE_APPEND;
    in_ch.value = 0;
    in_ch.new_value = 0;
    out_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_request(MODE_FIND, 5, 0);
    send_request(MODE_DELETE, 5, 0);
    send_request(MODE_INSERT, 5, 1);
    send_request(MODE_APPEND, 32'h7fffffff, 0);
    send_request(MODE_DELETE, 32'h7fffffff, 0);
    send_request(MODE_DELETE, 1, 0);
    send_request(MODE_PREPEND, 32'h80000000, 0);
    send_request(MODE_APPEND, 32'hffffffff, 0);
    send_request(MODE_FIND, 32'hffffffff, 0);
    send_request(MODE_INSERT, 32'h80000000, 32'h55555555);
    send_request(MODE_INSERT, 32'hffffffff, 32'haaaaaaaa);
    send_request(MODE_DELETE, 32'h7fffffff, 0);
    send_request(MODE_DELETE, 32'hffffffff, 0);
    send_request(MODE_FIND, 32'h7fffffff, 0);
    send_request(3'd5, 1, 2);
    send_request(3'd6, 1, 2);
    send_request(3'd7, 1, 2);
    for (int i = 0; i < 64; i++) send_request(MODE_APPEND, i, 0);
    send_request(MODE_APPEND, 9, 0);
    send_request(MODE_PREPEND, 9, 0);
    send_request(MODE_INSERT, 9, 9);
    send_request(MODE_FIND, 63, 0);
    send_request(MODE_DELETE, 63, 0);

    for (int i = 0; i < 1100; i++) begin
      steady = (i >= 400 && i < 550);
      roll = $urandom_range(99);
      if (roll < 22) mode = MODE_APPEND;
      else if (roll < 36) mode = MODE_PREPEND;
      else if (roll < 56) mode = MODE_FIND;
      else if (roll < 80) mode = MODE_DELETE;
      else if (roll < 97) mode = MODE_INSERT;
      else mode = MODE_W'($urandom_range(7, 5));
      send_request(mode, pick_key(), $urandom_range(1) ? $urandom : $urandom_range(15));
    end
    steady = 0;
    in_ch.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
